// ===== src/gda_pkg.sv =====
// gda_pkg: shared types, codes, constants and calendar helpers for the date unit
// no dependencies; imported by gda_addsub and gregorian_date_arith_unit
`default_nettype none

package gda_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int DIFF_W  = 23;

    localparam int YEAR_MAX_DEF    = 9999;
    localparam int OFFSET_BITS_DEF = 21;

    localparam int DIFF_MAX = 4194303;
    localparam int DIFF_MIN = -4194304;

    // days in one full 400 year cycle
    localparam int C_DAYS_400   = 146097;
    localparam int C_YEAR_CYCLE = 400;
    localparam int C_CENTURY    = 100;
    localparam int C_MONTHS     = 12;

    typedef enum logic [0:0] {
        CMD_ADD  = 1'b0,
        CMD_DIFF = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK           = 2'd0,
        STAT_BAD_DATE     = 2'd1,
        STAT_OUT_OF_RANGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ORD_BEFORE = 2'd0,
        ORD_EQUAL  = 2'd1,
        ORD_AFTER  = 2'd2
    } t_order;

    typedef enum logic [0:0] {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_TS400,
        S_TSYEAR,
        S_TSCHK,
        S_TSMON,
        S_RANGE,
        S_FS400,
        S_FSYEAR,
        S_FSMON
    } t_state;

    // leap test from position inside the 400 year cycle
    function automatic logic gda_leap(input logic [1:0] c4, input logic [6:0] c100,
                                      input logic first);
        return (c4 == 2'd0) && ((c100 != 7'd0) || first);
    endfunction

    function automatic logic [8:0] gda_year_len(input logic leap);
        return leap ? 9'd366 : 9'd365;
    endfunction

    function automatic logic [DAY_W-1:0] gda_month_days(input logic [MONTH_W-1:0] m,
                                                         input logic leap);
        logic [DAY_W-1:0] d;
        unique case (m)
            4'd2:                      d = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
            default:                   d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== src/gda_addsub.sv =====
// gda_addsub: shared add/subtract unit for the day-count accumulator
// depends on gda_pkg (alu op codes)
`default_nettype none

module gda_addsub #(
    parameter int WIDTH = gda_pkg::DIFF_W + 2
) (
    input  gda_pkg::t_alu_op    i_op,
    input  logic signed [WIDTH-1:0] i_a,
    input  logic signed [WIDTH-1:0] i_b,
    output logic signed [WIDTH-1:0] o_y
);
    import gda_pkg::*;

    logic             sub;
    logic [WIDTH-1:0] b_eff;

    // subtract as add of inverted operand plus carry in
    assign sub   = (i_op == ALU_SUB);
    assign b_eff = sub ? ~i_b : i_b;
    assign o_y   = i_a + $signed(b_eff) + $signed(WIDTH'(sub));

endmodule

`default_nettype wire

// ===== src/gregorian_date_arith_unit.sv =====
// gregorian_date_arith_unit: date plus day offset, and difference of two dates, via day counts
// depends on gda_pkg and gda_addsub; one beat in, one result beat out
// cmd 0 walks date A by 400 year cycles, years and months, adds the offset and converts back
// cmd 1 walks both dates the same way and takes B off A; one beat at a time
// the shared accumulator adder, stepped per 400 year cycle, year and month, sets the latency
// sync active-low reset idles the sequencer; o_done is a one-cycle pulse the receiver must take
`default_nettype none

module gregorian_date_arith_unit #(
    parameter int unsigned YEAR_MAX    = gda_pkg::YEAR_MAX_DEF,
    parameter int unsigned OFFSET_BITS = gda_pkg::OFFSET_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_cmd,
    input  logic [gda_pkg::YEAR_W-1:0]        i_a_year,
    input  logic [gda_pkg::MONTH_W-1:0]       i_a_month,
    input  logic [gda_pkg::DAY_W-1:0]         i_a_day,
    input  logic signed [OFFSET_BITS-1:0]     i_day_offset,
    input  logic [gda_pkg::YEAR_W-1:0]        i_b_year,
    input  logic [gda_pkg::MONTH_W-1:0]       i_b_month,
    input  logic [gda_pkg::DAY_W-1:0]         i_b_day,
    output logic                              o_done,
    output logic [gda_pkg::YEAR_W-1:0]        o_res_year,
    output logic [gda_pkg::MONTH_W-1:0]       o_res_month,
    output logic [gda_pkg::DAY_W-1:0]         o_res_day,
    output logic signed [gda_pkg::DIFF_W-1:0] o_day_difference,
    output gda_pkg::t_order                   o_order,
    output gda_pkg::t_status                  o_status
);
    import gda_pkg::*;

    // working year width: holds input years and every year up to the limit
    localparam int YW = ($clog2(YEAR_MAX + 1) > YEAR_W) ? $clog2(YEAR_MAX + 1) : YEAR_W;
    // day number of january 1 of the first year past the limit
    localparam int YS_END  = 365 * (YEAR_MAX + 1) + YEAR_MAX / 4 - YEAR_MAX / 100
                             + YEAR_MAX / 400 + 1;
    localparam int YS_BITS = $clog2(YS_END + 1);
    localparam int MAX_A   = (OFFSET_BITS > YS_BITS) ? OFFSET_BITS : YS_BITS;
    localparam int SER_BITS = ((MAX_A > DIFF_W) ? MAX_A : DIFF_W) + 2;

    // sequencer and strobe
    t_state r_state, n_state;
    logic   r_done, n_done;

    // captured beat
    t_cmd               r_cmd, n_cmd;
    logic [YEAR_W-1:0]  r_ay, n_ay, r_by, n_by;
    logic [MONTH_W-1:0] r_am, n_am, r_bm, n_bm;
    logic [DAY_W-1:0]   r_ad, n_ad, r_bd, n_bd;

    // working state
    logic signed [SER_BITS-1:0] r_ser, n_ser;
    logic [YW-1:0]              r_yr, n_yr;
    logic [MONTH_W-1:0]         r_mon, n_mon;
    logic [1:0]                 r_c4, n_c4;
    logic [6:0]                 r_c100, n_c100;
    logic                       r_first, n_first;
    logic                       r_sel, n_sel;

    // result registers
    logic [YEAR_W-1:0]        r_o_year, n_o_year;
    logic [MONTH_W-1:0]       r_o_month, n_o_month;
    logic [DAY_W-1:0]         r_o_day, n_o_day;
    logic signed [DIFF_W-1:0] r_o_diff, n_o_diff;
    t_order                   r_o_order, n_o_order;
    t_status                  r_o_status, n_o_status;

    // shared accumulator unit
    t_alu_op                    alu_op;
    logic signed [SER_BITS-1:0] alu_b;
    logic signed [SER_BITS-1:0] alu_y;

    // current date under conversion (A first, then B in cmd 1)
    logic [YEAR_W-1:0]  cur_y;
    logic [MONTH_W-1:0] cur_m;
    logic [DAY_W-1:0]   cur_d;
    logic               leap;
    logic               load_bad;
    logic               fs_phase;

    gda_addsub #(
        .WIDTH (SER_BITS)
    ) u_addsub (
        .i_op (alu_op),
        .i_a  (r_ser),
        .i_b  (alu_b),
        .o_y  (alu_y)
    );

    assign cur_y = r_sel ? r_by : r_ay;
    assign cur_m = r_sel ? r_bm : r_am;
    assign cur_d = r_sel ? r_bd : r_ad;

    // leap flag of the year the cycle counters point at
    assign leap = gda_leap(r_c4, r_c100, r_first);

    assign load_bad = (YW'(cur_y) > YW'(YEAR_MAX)) || (cur_m == '0)
                      || (cur_m > MONTH_W'(C_MONTHS)) || (cur_d == '0);

    // back conversion always counts down; date B is taken off the sum
    assign fs_phase = (r_state == S_FS400) || (r_state == S_FSYEAR) || (r_state == S_FSMON);
    assign alu_op   = (fs_phase || r_sel) ? ALU_SUB : ALU_ADD;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_ay       <= n_ay;
        r_am       <= n_am;
        r_ad       <= n_ad;
        r_by       <= n_by;
        r_bm       <= n_bm;
        r_bd       <= n_bd;
        r_ser      <= n_ser;
        r_yr       <= n_yr;
        r_mon      <= n_mon;
        r_c4       <= n_c4;
        r_c100     <= n_c100;
        r_first    <= n_first;
        r_sel      <= n_sel;
        r_o_year   <= n_o_year;
        r_o_month  <= n_o_month;
        r_o_day    <= n_o_day;
        r_o_diff   <= n_o_diff;
        r_o_order  <= n_o_order;
        r_o_status <= n_o_status;
    end

    always_comb begin
        n_state   = r_state;
        n_done    = 1'b0;
        n_cmd     = r_cmd;
        n_ay      = r_ay;
        n_am      = r_am;
        n_ad      = r_ad;
        n_by      = r_by;
        n_bm      = r_bm;
        n_bd      = r_bd;
        n_ser     = r_ser;
        n_yr      = r_yr;
        n_mon     = r_mon;
        n_c4      = r_c4;
        n_c100    = r_c100;
        n_first   = r_first;
        n_sel     = r_sel;
        alu_b     = '0;
        // result ports read zero outside the strobe cycle
        n_o_year   = '0;
        n_o_month  = '0;
        n_o_day    = '0;
        n_o_diff   = '0;
        n_o_order  = ORD_BEFORE;
        n_o_status = STAT_OK;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd   = t_cmd'(i_cmd);
                    n_ay    = i_a_year;
                    n_am    = i_a_month;
                    n_ad    = i_a_day;
                    n_by    = i_b_year;
                    n_bm    = i_b_month;
                    n_bd    = i_b_day;
                    n_sel   = 1'b0;
                    // cmd 0 seeds the sum with the offset, cmd 1 with zero
                    n_ser   = (t_cmd'(i_cmd) == CMD_ADD) ? SER_BITS'(i_day_offset) : '0;
                    n_state = S_LOAD;
                end
            end

            S_LOAD: begin
                alu_b = SER_BITS'(cur_d - DAY_W'(1));
                n_ser = alu_y;
                n_yr  = YW'(cur_y);
                n_mon = MONTH_W'(1);
                if (load_bad) begin
                    n_o_status = STAT_BAD_DATE;
                    n_done     = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_state = S_TS400;
                end
            end

            S_TS400: begin
                if (r_yr >= YW'(C_YEAR_CYCLE)) begin
                    alu_b = SER_BITS'(C_DAYS_400);
                    n_ser = alu_y;
                    n_yr  = r_yr - YW'(C_YEAR_CYCLE);
                end else begin
                    n_c4    = '0;
                    n_c100  = '0;
                    n_first = 1'b1;
                    n_state = S_TSYEAR;
                end
            end

            S_TSYEAR: begin
                if (r_yr != '0) begin
                    alu_b   = SER_BITS'(gda_year_len(leap));
                    n_ser   = alu_y;
                    n_yr    = r_yr - YW'(1);
                    n_c4    = r_c4 + 2'd1;
                    n_c100  = (r_c100 == 7'(C_CENTURY - 1)) ? '0 : r_c100 + 7'd1;
                    n_first = 1'b0;
                end else begin
                    n_state = S_TSCHK;
                end
            end

            S_TSCHK: begin
                // counters now sit on the date's own year
                if (cur_d > gda_month_days(cur_m, leap)) begin
                    n_o_status = STAT_BAD_DATE;
                    n_done     = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_state = S_TSMON;
                end
            end

            S_TSMON: begin
                if (r_mon < cur_m) begin
                    alu_b = SER_BITS'(gda_month_days(r_mon, leap));
                    n_ser = alu_y;
                    n_mon = r_mon + MONTH_W'(1);
                end else if (r_cmd == CMD_DIFF) begin
                    if (!r_sel) begin
                        n_sel   = 1'b1;
                        n_state = S_LOAD;
                    end else begin
                        if (r_ser < 0) begin
                            n_o_order = ORD_BEFORE;
                        end else if (r_ser == 0) begin
                            n_o_order = ORD_EQUAL;
                        end else begin
                            n_o_order = ORD_AFTER;
                        end
                        if (r_ser > SER_BITS'(DIFF_MAX)) begin
                            n_o_diff   = DIFF_W'(DIFF_MAX);
                            n_o_status = STAT_OUT_OF_RANGE;
                        end else if (r_ser < SER_BITS'(DIFF_MIN)) begin
                            n_o_diff   = DIFF_W'(DIFF_MIN);
                            n_o_status = STAT_OUT_OF_RANGE;
                        end else begin
                            n_o_diff = r_ser[DIFF_W-1:0];
                        end
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_RANGE;
                end
            end

            S_RANGE: begin
                if ((r_ser < 0) || (r_ser >= SER_BITS'(YS_END))) begin
                    n_o_status = STAT_OUT_OF_RANGE;
                    n_done     = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_yr    = '0;
                    n_state = S_FS400;
                end
            end

            S_FS400: begin
                alu_b = SER_BITS'(C_DAYS_400);
                if (!alu_y[SER_BITS-1]) begin
                    n_ser = alu_y;
                    n_yr  = r_yr + YW'(C_YEAR_CYCLE);
                end else begin
                    n_c4    = '0;
                    n_c100  = '0;
                    n_first = 1'b1;
                    n_state = S_FSYEAR;
                end
            end

            S_FSYEAR: begin
                alu_b = SER_BITS'(gda_year_len(leap));
                if (!alu_y[SER_BITS-1]) begin
                    n_ser   = alu_y;
                    n_yr    = r_yr + YW'(1);
                    n_c4    = r_c4 + 2'd1;
                    n_c100  = (r_c100 == 7'(C_CENTURY - 1)) ? '0 : r_c100 + 7'd1;
                    n_first = 1'b0;
                end else begin
                    n_mon   = MONTH_W'(1);
                    n_state = S_FSMON;
                end
            end

            S_FSMON: begin
                alu_b = SER_BITS'(gda_month_days(r_mon, leap));
                if ((r_mon < MONTH_W'(C_MONTHS)) && !alu_y[SER_BITS-1]) begin
                    n_ser = alu_y;
                    n_mon = r_mon + MONTH_W'(1);
                end else begin
                    // remaining count is the zero-based day of the month
                    n_o_year  = r_yr[YEAR_W-1:0];
                    n_o_month = r_mon;
                    n_o_day   = r_ser[DAY_W-1:0] + DAY_W'(1);
                    n_done    = 1'b1;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy             = (r_state != S_IDLE);
    assign o_done           = r_done;
    assign o_res_year       = r_o_year;
    assign o_res_month      = r_o_month;
    assign o_res_day        = r_o_day;
    assign o_day_difference = r_o_diff;
    assign o_order          = r_o_order;
    assign o_status         = r_o_status;

`ifndef SYNTHESIS
    // a result beat only follows a cycle of work
    a_done_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(r_state) != S_IDLE))
        else $error("result strobe without preceding work");

    // an accepted beat makes the unit busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not start the sequencer");

    // a good cmd 0 result never carries day zero
    a_day_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == STAT_OK) && (r_cmd == CMD_ADD)) |-> (o_res_day != '0))
        else $error("cmd 0 result with day zero");

    // month counter stays within the year during back conversion
    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FSMON) |-> ((r_mon >= MONTH_W'(1)) && (r_mon <= MONTH_W'(C_MONTHS))))
        else $error("month counter out of range");

    // remaining day count never goes negative during back conversion
    a_count_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fs_phase |-> !r_ser[SER_BITS-1])
        else $error("negative day count in back conversion");
`endif

endmodule

`default_nettype wire
